// ===== hdl/spq_pkg.sv =====
package spq_pkg;

	typedef enum logic [2:0] {
		OP_INSERT   = 3'd0,
		OP_DEL_PRIO = 3'd1,
		OP_DEL_TAG  = 3'd2,
		OP_SEARCH   = 3'd3,
		OP_POP      = 3'd4
	} op_t;

	typedef enum logic [1:0] {
		ST_OK   = 2'd0,
		ST_MISS = 2'd1,
		ST_FULL = 2'd2
	} status_t;

	typedef struct packed {
		logic [2:0]  op;
		logic [15:0] prio;
		logic [31:0] task_tag;
	} req_t;

	typedef struct packed {
		status_t     status;
		logic [31:0] out_tag;
		logic [15:0] out_prio;
		logic [4:0]  entry_count;
		logic        is_empty;
		logic        is_full;
	} rsp_t;

	typedef struct packed {
		logic [15:0] prio;
		logic [31:0] tag;
	} entry_t;

	typedef struct packed {
		logic load_new;
		logic take_left;
		logic take_right;
	} cell_cmd_t;

	typedef struct packed {
		logic ge;
		logic eq_prio;
		logic eq_tag;
	} cell_flag_t;

endpackage

// ===== hdl/spq_cell.sv =====
module spq_cell
	import spq_pkg::*;
(
	input  logic       clk,
	input  cell_cmd_t  cmd,
	input  entry_t     new_entry,
	input  entry_t     left_entry,
	input  entry_t     right_entry,
	output entry_t     entry,
	output cell_flag_t flag
);

	entry_t entry_q;

	always_ff @(posedge clk) begin
		if (cmd.take_left) begin
			entry_q <= left_entry;
		end else if (cmd.load_new) begin
			entry_q <= new_entry;
		end else if (cmd.take_right) begin
			entry_q <= right_entry;
		end
	end

	assign entry        = entry_q;
	assign flag.ge      = entry_q.prio >= new_entry.prio;
	assign flag.eq_prio = entry_q.prio == new_entry.prio;
	assign flag.eq_tag  = entry_q.tag == new_entry.tag;

endmodule

// ===== hdl/spq_scan.sv =====
module spq_scan #(
	parameter int N = 16
) (
	input  logic [N-1:0] hit,
	output logic [N-1:0] pre,
	output logic [N-1:0] first
);

	localparam int LV = $clog2(N);

	logic [N-1:0] lvl [LV+1];

	assign lvl[0] = hit;

	for (genvar k = 0; k < LV; k++) begin : g_lvl
		assign lvl[k+1] = lvl[k] | (lvl[k] << (2 ** k));
	end

	assign pre   = lvl[LV];
	assign first = hit & ~(pre << 1);

endmodule

// ===== hdl/sorted_priority_queue.sv =====
// The response is registered and shows in the cycle after the request is taken.
// Throughput: one request per cycle while the response side does not stall.
// Each slot is a cell; the first-match scan is a prefix tree of log2(DEPTH) levels.
// Reset: asynchronous, active low; empties the list (count zero, no response pending).
// Slot contents are not cleared and are never read before being written.
module sorted_priority_queue
	import spq_pkg::*;
#(
	parameter int DEPTH = 16
) (
	input  logic clk,
	input  logic arst_n,
	input  logic req_valid,
	output logic req_stall,
	input  req_t req,
	output logic rsp_valid,
	input  logic rsp_stall,
	output rsp_t rsp
);

	localparam int COUNT_W = $clog2(DEPTH + 1);

	logic [COUNT_W-1:0] count_q;
	logic [COUNT_W-1:0] count_next;
	logic               rsp_valid_q;
	rsp_t               rsp_q;
	logic               fire;

	entry_t     new_entry;
	entry_t     cell_entry [DEPTH];
	cell_flag_t cell_flag  [DEPTH];
	cell_cmd_t  cell_cmd   [DEPTH];
	logic [DEPTH-1:0] slot_used;
	logic [DEPTH-1:0] ins_ge;
	logic [DEPTH-1:0] hit;
	logic [DEPTH-1:0] pre;
	logic [DEPTH-1:0] first;

	logic is_ins, is_del, is_find, full, found;
	logic [15:0] sel_prio;
	logic [31:0] sel_tag;
	logic [COUNT_W+4:0] count_ext;
	rsp_t rsp_d;

	assign fire      = req_valid && !req_stall;
	assign req_stall = rsp_valid_q && rsp_stall;
	assign new_entry = '{prio: req.prio, tag: req.task_tag};

	assign full    = count_q == COUNT_W'(DEPTH);
	assign is_ins  = req.op == OP_INSERT;
	assign is_find = req.op == OP_DEL_PRIO || req.op == OP_DEL_TAG
		|| req.op == OP_SEARCH || req.op == OP_POP;
	assign is_del  = req.op == OP_DEL_PRIO || req.op == OP_DEL_TAG || req.op == OP_POP;

	for (genvar i = 0; i < DEPTH; i++) begin : g_cell
		assign slot_used[i] = COUNT_W'(i) < count_q;
		assign ins_ge[i]    = !slot_used[i] || cell_flag[i].ge;

		always_comb begin
			case (req.op)
				OP_DEL_PRIO, OP_SEARCH: hit[i] = slot_used[i] && cell_flag[i].eq_prio;
				OP_DEL_TAG:             hit[i] = slot_used[i] && cell_flag[i].eq_tag;
				OP_POP:                 hit[i] = (i == 0) && slot_used[i];
				default:                hit[i] = 1'b0;
			endcase
		end

		if (i == 0) begin : g_head
			assign cell_cmd[i].take_left = 1'b0;
		end else begin : g_body
			assign cell_cmd[i].take_left = fire && is_ins && !full && ins_ge[i-1];
		end
		assign cell_cmd[i].load_new = fire && is_ins && !full && ins_ge[i];

		if (i == DEPTH - 1) begin : g_tail
			assign cell_cmd[i].take_right = 1'b0;
			spq_cell u_cell (
				.clk         (clk),
				.cmd         (cell_cmd[i]),
				.new_entry   (new_entry),
				.left_entry  (cell_entry[i-1]),
				.right_entry (cell_entry[i]),
				.entry       (cell_entry[i]),
				.flag        (cell_flag[i])
			);
		end else begin : g_mid
			assign cell_cmd[i].take_right = fire && is_del && pre[i];
			if (i == 0) begin : g_first
				spq_cell u_cell (
					.clk         (clk),
					.cmd         (cell_cmd[i]),
					.new_entry   (new_entry),
					.left_entry  (new_entry),
					.right_entry (cell_entry[i+1]),
					.entry       (cell_entry[i]),
					.flag        (cell_flag[i])
				);
			end else begin : g_inner
				spq_cell u_cell (
					.clk         (clk),
					.cmd         (cell_cmd[i]),
					.new_entry   (new_entry),
					.left_entry  (cell_entry[i-1]),
					.right_entry (cell_entry[i+1]),
					.entry       (cell_entry[i]),
					.flag        (cell_flag[i])
				);
			end
		end
	end

	spq_scan #(.N(DEPTH)) u_scan (
		.hit   (hit),
		.pre   (pre),
		.first (first)
	);

	assign found = pre[DEPTH-1];

	always_comb begin
		sel_prio = '0;
		sel_tag  = '0;
		for (int i = 0; i < DEPTH; i++) begin
			sel_prio = sel_prio | (first[i] ? cell_entry[i].prio : 16'd0);
			sel_tag  = sel_tag | (first[i] ? cell_entry[i].tag : 32'd0);
		end
	end

	always_comb begin
		count_next       = count_q;
		rsp_d.status     = ST_MISS;
		rsp_d.out_tag    = '0;
		rsp_d.out_prio   = '0;
		if (is_ins) begin
			if (full) begin
				rsp_d.status = ST_FULL;
			end else begin
				rsp_d.status = ST_OK;
				count_next   = count_q + COUNT_W'(1);
			end
		end else if (is_find && found) begin
			rsp_d.status   = ST_OK;
			rsp_d.out_tag  = sel_tag;
			rsp_d.out_prio = sel_prio;
			if (is_del) begin
				count_next = count_q - COUNT_W'(1);
			end
		end
		count_ext         = {5'd0, count_next};
		rsp_d.entry_count = count_ext[4:0];
		rsp_d.is_empty    = count_next == '0;
		rsp_d.is_full     = count_next == COUNT_W'(DEPTH);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q     <= '0;
			rsp_valid_q <= 1'b0;
		end else begin
			if (fire) begin
				count_q     <= count_next;
				rsp_valid_q <= 1'b1;
			end else if (!rsp_stall) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (fire) begin
			rsp_q <= rsp_d;
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= COUNT_W'(DEPTH))
		else $error("entry count above depth");

	a_first_onehot: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot0(first))
		else $error("more than one first match");

	a_insert_count: assert property (@(posedge clk) disable iff (!arst_n)
		fire && is_ins && !full |=> count_q == $past(count_q) + COUNT_W'(1))
		else $error("insert did not advance count");

	a_stall_pending: assert property (@(posedge clk) disable iff (!arst_n)
		req_stall |-> rsp_valid_q)
		else $error("request stalled with no response pending");

	a_rsp_after_fire: assert property (@(posedge clk) disable iff (!arst_n)
		fire |=> rsp_valid_q)
		else $error("accepted request gave no response");

endmodule

// ===== verif/tb_sorted_priority_queue.sv =====
module tb_sorted_priority_queue;
	import spq_pkg::*;

	timeunit 1ns;
	timeprecision 1ps;

	localparam int DEPTH = 16;
	localparam int QUIET_LIMIT = 5000;
	localparam int HOLD_CYCLES = 300;
	localparam int ITEMS_PER_PHASE = 225;

	localparam logic [2:0] OP_RSVD_A = 3'd5;
	localparam logic [2:0] OP_RSVD_C = 3'd7;

	class spq_scoreboard;
		logic [15:0] slot_prio [DEPTH];
		logic [31:0] slot_tag [DEPTH];
		int unsigned fill;
		rsp_t pending[$];
		int errors;

		function new();
			fill = 0;
			errors = 0;
		endfunction

		function void drop_slot(int unsigned pos);
			int unsigned k;
			for (k = pos; k + 1 < fill; k++) begin
				slot_prio[k] = slot_prio[k + 1];
				slot_tag[k] = slot_tag[k + 1];
			end
			fill--;
		endfunction

		function void note_request(req_t r);
			rsp_t want;
			int unsigned pos;
			int unsigned k;
			logic hit;
			want = '0;
			want.status = ST_MISS;
			case (r.op)
				OP_INSERT: begin
					if (fill >= DEPTH) begin
						want.status = ST_FULL;
					end else begin
						pos = 0;
						while (pos < fill && slot_prio[pos] < r.prio)
							pos++;
						for (k = fill; k > pos; k--) begin
							slot_prio[k] = slot_prio[k - 1];
							slot_tag[k] = slot_tag[k - 1];
						end
						slot_prio[pos] = r.prio;
						slot_tag[pos] = r.task_tag;
						fill++;
						want.status = ST_OK;
					end
				end
				OP_DEL_PRIO, OP_DEL_TAG, OP_SEARCH: begin
					pos = 0;
					hit = 1'b0;
					while (pos < fill && !hit) begin
						hit = (r.op == OP_DEL_TAG) ? (slot_tag[pos] == r.task_tag)
							: (slot_prio[pos] == r.prio);
						if (!hit)
							pos++;
					end
					if (hit) begin
						want.status = ST_OK;
						want.out_tag = slot_tag[pos];
						want.out_prio = slot_prio[pos];
						if (r.op != OP_SEARCH)
							drop_slot(pos);
					end
				end
				OP_POP: begin
					if (fill > 0) begin
						want.status = ST_OK;
						want.out_tag = slot_tag[0];
						want.out_prio = slot_prio[0];
						drop_slot(0);
					end
				end
				default: ;
			endcase
			want.entry_count = 5'(fill);
			want.is_empty = (fill == 0);
			want.is_full = (fill >= DEPTH);
			pending.push_back(want);
		endfunction

		task report(string msg);
			$display("[%0t] error: %s", $time, msg);
			errors++;
		endtask

		task check_response(rsp_t got);
			rsp_t want;
			if (pending.size() == 0) begin
				report("response with no request outstanding");
			end else begin
				want = pending.pop_front();
				if (got.status !== want.status)
					report($sformatf("status %0d, want %0d", got.status, want.status));
				if (got.out_tag !== want.out_tag)
					report($sformatf("out_tag %h, want %h", got.out_tag, want.out_tag));
				if (got.out_prio !== want.out_prio)
					report($sformatf("out_prio %h, want %h", got.out_prio, want.out_prio));
				if (got.entry_count !== want.entry_count)
					report($sformatf("entry_count %0d, want %0d", got.entry_count,
						want.entry_count));
				if (got.is_empty !== want.is_empty)
					report($sformatf("is_empty %b, want %b", got.is_empty, want.is_empty));
				if (got.is_full !== want.is_full)
					report($sformatf("is_full %b, want %b", got.is_full, want.is_full));
			end
		endtask
	endclass

	logic clk;
	logic arst_n = 1'b0;
	logic req_valid = 1'b0;
	logic req_stall;
	req_t req = '0;
	logic rsp_valid;
	logic rsp_stall = 1'b0;
	rsp_t rsp;

	int send_idle_pct = 0;
	int rsp_stall_pct = 0;
	int hold_left = 0;

	spq_scoreboard sb = new();

	sorted_priority_queue #(
		.DEPTH(DEPTH)
	) u_top (
		.clk(clk),
		.arst_n(arst_n),
		.req_valid(req_valid),
		.req_stall(req_stall),
		.req(req),
		.rsp_valid(rsp_valid),
		.rsp_stall(rsp_stall),
		.rsp(rsp)
	);

	always begin
		clk = 1'b0;
		#2;
		clk = 1'b1;
		#2;
	end

	// hold off for a counted stretch, else stall at random
	always @(negedge clk) begin
		if (hold_left > 0) begin
			rsp_stall <= 1'b1;
			hold_left <= hold_left - 1;
		end else begin
			rsp_stall <= ($urandom_range(99) < rsp_stall_pct);
		end
	end

	always @(posedge clk) begin
		if (rsp_valid && !rsp_stall)
			sb.check_response(rsp);
		if (req_valid && !req_stall)
			sb.note_request(req);
	end

	initial begin
		int quiet;
		quiet = 0;
		while (quiet < QUIET_LIMIT) begin
			@(posedge clk);
			if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall))
				quiet = 0;
			else
				quiet++;
		end
		$display("SCOREBOARD MISMATCH");
		$finish;
	end

	task automatic issue(input logic [2:0] op, input logic [15:0] prio,
		input logic [31:0] tag);
		req_t r;
		r.op = op;
		r.prio = prio;
		r.task_tag = tag;
		while ($urandom_range(99) < send_idle_pct) begin
			req_valid <= 1'b0;
			@(negedge clk);
		end
		req_valid <= 1'b1;
		req <= r;
		do
			@(posedge clk);
		while (req_stall);
		@(negedge clk);
	endtask

	task automatic drain();
		req_valid <= 1'b0;
		while (sb.pending.size() != 0)
			@(negedge clk);
		repeat (2) @(negedge clk);
	endtask

	task automatic run_phase(input int items, input int send_pct, input int rsp_pct,
		input int hold);
		int n;
		int pick;
		int grow;
		logic [2:0] op;
		logic [15:0] p;
		logic [31:0] t;
		send_idle_pct = send_pct;
		rsp_stall_pct = rsp_pct;
		hold_left = hold;
		for (n = 0; n < items; n++) begin
			// alternate filling and emptying stretches
			grow = ((n / 40) % 2 == 0) ? 75 : 20;
			pick = $urandom_range(99);
			if (pick < grow)
				op = OP_INSERT;
			else if (pick < 96)
				op = 3'($urandom_range(OP_DEL_PRIO, OP_POP));
			else
				op = 3'($urandom_range(OP_RSVD_A, OP_RSVD_C));
			pick = $urandom_range(99);
			if (pick < 50 && sb.fill > 0)
				p = sb.slot_prio[$urandom_range(sb.fill - 1)];
			else if (pick < 80)
				p = 16'($urandom_range(15));
			else if (pick < 85)
				p = 16'hFFFF;
			else if (pick < 88)
				p = 16'h0000;
			else
				p = 16'($urandom());
			pick = $urandom_range(99);
			if (pick < 50 && sb.fill > 0)
				t = sb.slot_tag[$urandom_range(sb.fill - 1)];
			else if (pick < 70)
				t = $urandom_range(15);
			else if (pick < 75)
				t = 32'hFFFF_FFFF;
			else
				t = $urandom();
			issue(op, p, t);
		end
	endtask

	initial begin
		int k;
		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		issue(OP_POP, 16'h0000, 32'h0000_0000);
		issue(OP_SEARCH, 16'h0000, 32'h0000_0000);
		issue(OP_DEL_PRIO, 16'hFFFF, 32'h0000_0000);
		issue(OP_DEL_TAG, 16'h0000, 32'hFFFF_FFFF);
		issue(OP_RSVD_A, 16'hFFFF, 32'hFFFF_FFFF);
		issue(OP_INSERT, 16'hFFFF, 32'hFFFF_FFFF);
		issue(OP_INSERT, 16'h0000, 32'h0000_0000);
		for (k = 0; k < DEPTH - 2; k++)
			issue(OP_INSERT, (k < 4) ? 16'd100 : 16'(k * 1000), 32'(k + 1));
		issue(OP_INSERT, 16'd5, 32'h0000_BEEF);
		issue(OP_SEARCH, 16'd100, 32'h0000_0000);
		issue(OP_DEL_TAG, 16'h0000, 32'hFFFF_FFFF);
		issue(OP_DEL_PRIO, 16'd100, 32'h0000_0000);
		issue(OP_POP, 16'h0000, 32'h0000_0000);
		drain();

		run_phase(ITEMS_PER_PHASE, 0, 0, HOLD_CYCLES);
		drain();
		run_phase(ITEMS_PER_PHASE, 63, 0, 0);
		drain();
		run_phase(ITEMS_PER_PHASE, 0, 63, 0);
		drain();
		run_phase(ITEMS_PER_PHASE, 21, 21, 0);
		drain();

		if (sb.errors == 0)
			$display("SCOREBOARD CLEAN");
		else
			$display("SCOREBOARD MISMATCH");
		$finish;
	end

endmodule
